### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/brsa_pkg.sv
// Types and constants of the bitmap run scan allocator.
`default_nettype none

package brsa_pkg;

    localparam int IDX_W       = 11;
    localparam int OP_W        = 3;
    localparam int RUN_START_W = 10;
    localparam int STATUS_W    = 2;
    localparam int CHUNK_BITS  = 8;
    localparam int CHUNK_SH    = 3;

    localparam logic [IDX_W-1:0] BIT_COUNT_RESET = 11'd1024;

    localparam logic [OP_W-1:0] OP_FILL      = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE     = 3'd1;
    localparam logic [OP_W-1:0] OP_READ      = 3'd2;
    localparam logic [OP_W-1:0] OP_SCAN      = 3'd3;
    localparam logic [OP_W-1:0] OP_SCAN_FLIP = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NONE = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] start_index;
        logic [IDX_W-1:0] end_index;
        logic [IDX_W-1:0] run_length;
        logic             bit_value_in;
    } brsa_in_t;

    typedef struct packed {
        logic                   bit_value_out;
        logic [RUN_START_W-1:0] run_start;
        logic [STATUS_W-1:0]    status;
    } brsa_out_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_FILL,
        S_SEEK,
        S_LOAD,
        S_CHUNK,
        S_WB,
        S_FLIP,
        S_FIN
    } brsa_state_t;

    typedef enum logic [1:0] {
        PASS_SCAN,
        PASS_WRITE,
        PASS_READ
    } brsa_pass_t;

endpackage

`default_nettype wire

### rtl/brsa_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none

module brsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                          wdata,
    output      logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/bitmap_run_scan_allocator.sv
// Bitmap run scan allocator: top level with sequencer and shared chunk unit.
`default_nettype none

// Usage:
//  in_valid/in_stall/in_data carry one operation per beat (fill, write range,
//  read bit, scan, scan and flip). out_valid/out_stall/out_data return exactly
//  one result beat per operation, in order. cfg_valid/cfg_ready/cfg_data write
//  bit_count; cfg_ready is always high, write only while the block is idle.
//  After reset a clearing pass writes zero to every word, with in_stall high.
//  One operation at a time: in_stall is high from the accepting edge until the
//  result is loaded into the output register. The bitmap RAM has one port and
//  is walked a word at a time from word 0; every word that overlaps the window
//  is read (seek), loaded (load) and scanned one 8-bit chunk at a time (chunk),
//  plus a write-back step for range writes. Words below the window start are
//  only passed over in the seek state. Fill writes every word in turn, and an
//  argument error goes from decode straight to the finish state.
//  Scan and flip adds a second write pass over the found run.
//  A stalled result holds in the output register; the next operation is taken
//  meanwhile and its result waits in the finish state until the slot frees.

module bitmap_run_scan_allocator import brsa_pkg::*; #(
    parameter int MAX_BITS  = 1024,
    parameter int WORD_BITS = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output      logic             cfg_ready,
    input  wire logic [IDX_W-1:0] cfg_data,
    input  wire logic             in_valid,
    output      logic             in_stall,
    input  wire brsa_in_t         in_data,
    output      logic             out_valid,
    input  wire logic             out_stall,
    output      brsa_out_t        out_data
);

    localparam int WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int NCHUNK     = (WORD_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int C_W        = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int EXT_BITS   = NCHUNK * CHUNK_BITS;
    // positions cover the whole store plus one word, and any 12-bit window end
    localparam int POS_W      = $clog2(WORD_COUNT * WORD_BITS + WORD_BITS + 4096 + 1);
    localparam int CNT_MAX    = (MAX_BITS < (1 << IDX_W)) ? MAX_BITS : (1 << IDX_W) - 1;

    localparam logic [IDX_W-1:0] CNT_MAX_V   = IDX_W'(CNT_MAX);
    localparam logic [WA_W-1:0]  LAST_WORD   = WA_W'(WORD_COUNT - 1);
    localparam logic [C_W-1:0]   LAST_CHUNK  = C_W'(NCHUNK - 1);
    localparam logic [POS_W-1:0] WORD_STEP   = POS_W'(WORD_BITS);
    localparam logic [POS_W-1:0] CHUNK_STEP  = POS_W'(CHUNK_BITS);

    // control state
    brsa_state_t          state_reg, state_next;
    logic [WA_W-1:0]      waddr_reg, waddr_next;
    logic                 out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]     bit_count_reg, bit_count_next;

    // working registers
    brsa_in_t             item_reg, item_next;
    brsa_pass_t           pass_reg, pass_next;
    logic [POS_W-1:0]     base_reg, base_next;
    logic [POS_W-1:0]     cb_reg, cb_next;
    logic [C_W-1:0]       c_reg, c_next;
    logic [POS_W-1:0]     lo_reg, lo_next;
    logic [POS_W-1:0]     hi_reg, hi_next;
    logic [IDX_W-1:0]     run_reg, run_next;
    logic                 val_reg, val_next;
    logic [POS_W-1:0]     hit_pos_reg, hit_pos_next;
    logic [EXT_BITS-1:0]  word_reg, word_next;
    logic                 res_bit_reg, res_bit_next;
    logic [RUN_START_W-1:0] res_start_reg, res_start_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    brsa_out_t            out_reg, out_next;

    // RAM port
    logic                 ram_we;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;

    // chunk unit
    logic [CHUNK_BITS-1:0] cur_chunk;
    logic [CHUNK_BITS-1:0] chunk_new;
    logic [IDX_W-1:0]      chunk_run;
    logic                  chunk_hit;
    logic [POS_W-1:0]      chunk_hit_pos;
    logic                  chunk_rd_bit;

    // misc
    logic [IDX_W-1:0]     cnt;
    logic [IDX_W:0]       s_plus_len;
    logic [POS_W-1:0]     adv_base;
    logic [POS_W-1:0]     run_first;
    logic                 last_word;
    logic                 last_chunk;
    logic                 pass_over;

    brsa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (waddr_reg),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign cnt        = (bit_count_reg > CNT_MAX_V) ? CNT_MAX_V : bit_count_reg;
    assign s_plus_len = {1'b0, item_reg.start_index} + {1'b0, item_reg.run_length};
    assign adv_base   = base_reg + WORD_STEP;
    assign last_word  = (waddr_reg == LAST_WORD);
    assign last_chunk = (c_reg == LAST_CHUNK);
    assign pass_over  = last_word || (adv_base >= hi_reg);
    assign run_first  = hit_pos_reg + POS_W'(1) - POS_W'(item_reg.run_length);

    // One 8-bit chunk per cycle: window mask, run count, read tap, range write.
    always_comb
    begin : chunk_unit
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] wpos;
        logic             in_win;
        logic [IDX_W-1:0] run_v;
        logic             hit_v;
        pos           = '0;
        wpos          = '0;
        in_win        = 1'b0;
        cur_chunk     = word_reg[c_reg*CHUNK_BITS +: CHUNK_BITS];
        chunk_new     = cur_chunk;
        chunk_hit_pos = '0;
        chunk_rd_bit  = 1'b0;
        run_v         = run_reg;
        hit_v         = 1'b0;
        for (int j = 0; j < CHUNK_BITS; j++)
        begin
            pos    = cb_reg + POS_W'(j);
            wpos   = (POS_W'(c_reg) << CHUNK_SH) + POS_W'(j);
            in_win = (wpos < WORD_STEP) && (pos >= lo_reg) && (pos < hi_reg);
            if (in_win && !hit_v)
            begin
                case (pass_reg)
                    PASS_SCAN:
                    begin
                        if (cur_chunk[j] == val_reg)
                        begin
                            run_v = run_v + IDX_W'(1);
                            if (run_v == item_reg.run_length)
                            begin
                                hit_v         = 1'b1;
                                chunk_hit_pos = pos;
                            end
                        end
                        else
                        begin
                            run_v = '0;
                        end
                    end
                    PASS_READ:
                    begin
                        hit_v        = 1'b1;
                        chunk_rd_bit = cur_chunk[j];
                    end
                    PASS_WRITE:
                    begin
                        chunk_new[j] = val_reg;
                    end
                    default:
                    begin
                        hit_v = 1'b0;
                    end
                endcase
            end
        end
        chunk_run = run_v;
        chunk_hit = hit_v;
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        waddr_next      = waddr_reg;
        out_valid_next  = out_valid_reg && out_stall;
        bit_count_next  = bit_count_reg;
        item_next       = item_reg;
        pass_next       = pass_reg;
        base_next       = base_reg;
        cb_next         = cb_reg;
        c_next          = c_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        run_next        = run_reg;
        val_next        = val_reg;
        hit_pos_next    = hit_pos_reg;
        word_next       = word_reg;
        res_bit_next    = res_bit_reg;
        res_start_next  = res_start_reg;
        res_status_next = res_status_reg;
        out_next        = out_reg;
        ram_we          = 1'b0;
        ram_wdata       = word_reg[WORD_BITS-1:0];

        if (cfg_valid && cfg_ready)
        begin
            bit_count_next = cfg_data;
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (last_word)
                begin
                    waddr_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    waddr_next = waddr_reg + WA_W'(1);
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_bit_next    = 1'b0;
                res_start_next  = '0;
                res_status_next = STAT_OK;
                base_next       = '0;
                waddr_next      = '0;
                run_next        = '0;
                val_next        = item_reg.bit_value_in;
                lo_next         = POS_W'(item_reg.start_index);
                case (item_reg.op)
                    OP_FILL:
                    begin
                        state_next = S_FILL;
                    end
                    OP_WRITE:
                    begin
                        pass_next = PASS_WRITE;
                        hi_next   = POS_W'(s_plus_len);
                        if ((item_reg.start_index >= cnt) || (s_plus_len > {1'b0, cnt}))
                        begin
                            res_status_next = STAT_BAD;
                            state_next      = S_FIN;
                        end
                        else if (item_reg.run_length == '0)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            state_next = S_SEEK;
                        end
                    end
                    OP_READ:
                    begin
                        pass_next = PASS_READ;
                        hi_next   = POS_W'(item_reg.start_index) + POS_W'(1);
                        if (item_reg.start_index >= cnt)
                        begin
                            res_status_next = STAT_BAD;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            state_next = S_SEEK;
                        end
                    end
                    OP_SCAN, OP_SCAN_FLIP:
                    begin
                        pass_next = PASS_SCAN;
                        hi_next   = POS_W'(item_reg.end_index);
                        if ((item_reg.run_length == '0)
                            || (item_reg.start_index > item_reg.end_index)
                            || (item_reg.end_index > cnt))
                        begin
                            res_status_next = STAT_BAD;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            state_next = S_SEEK;
                        end
                    end
                    default:
                    begin
                        res_status_next = STAT_BAD;
                        state_next      = S_FIN;
                    end
                endcase
            end

            S_FILL:
            begin
                ram_we    = 1'b1;
                ram_wdata = {WORD_BITS{val_reg}};
                if (last_word)
                begin
                    waddr_next = '0;
                    state_next = S_FIN;
                end
                else
                begin
                    waddr_next = waddr_reg + WA_W'(1);
                end
            end

            S_SEEK:
            begin
                if (adv_base <= lo_reg)
                begin
                    // whole word below the window
                    if (last_word)
                    begin
                        if (pass_reg == PASS_SCAN)
                        begin
                            res_status_next = STAT_NONE;
                        end
                        state_next = S_FIN;
                    end
                    else
                    begin
                        base_next  = adv_base;
                        waddr_next = waddr_reg + WA_W'(1);
                    end
                end
                else if (base_reg >= hi_reg)
                begin
                    if (pass_reg == PASS_SCAN)
                    begin
                        res_status_next = STAT_NONE;
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    // read issued here, data arrives next cycle
                    state_next = S_LOAD;
                end
            end

            S_LOAD:
            begin
                word_next  = EXT_BITS'(ram_rdata);
                cb_next    = base_reg;
                c_next     = '0;
                state_next = S_CHUNK;
            end

            S_CHUNK:
            begin
                run_next = chunk_run;
                word_next[c_reg*CHUNK_BITS +: CHUNK_BITS] = chunk_new;
                if (chunk_hit)
                begin
                    if (pass_reg == PASS_READ)
                    begin
                        res_bit_next = chunk_rd_bit;
                        state_next   = S_FIN;
                    end
                    else
                    begin
                        hit_pos_next = chunk_hit_pos;
                        state_next   = S_FLIP;
                    end
                end
                else if (!last_chunk)
                begin
                    c_next  = c_reg + C_W'(1);
                    cb_next = cb_reg + CHUNK_STEP;
                end
                else if (pass_reg == PASS_WRITE)
                begin
                    state_next = S_WB;
                end
                else if (pass_over)
                begin
                    if (pass_reg == PASS_SCAN)
                    begin
                        res_status_next = STAT_NONE;
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    base_next  = adv_base;
                    waddr_next = waddr_reg + WA_W'(1);
                    state_next = S_SEEK;
                end
            end

            S_WB:
            begin
                ram_we = 1'b1;
                if (pass_over)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    base_next  = adv_base;
                    waddr_next = waddr_reg + WA_W'(1);
                    state_next = S_SEEK;
                end
            end

            S_FLIP:
            begin
                res_start_next = run_first[RUN_START_W-1:0];
                if (item_reg.op == OP_SCAN_FLIP)
                begin
                    // second pass: invert the run just found
                    pass_next  = PASS_WRITE;
                    lo_next    = run_first;
                    hi_next    = hit_pos_reg + POS_W'(1);
                    val_next   = !val_reg;
                    base_next  = '0;
                    waddr_next = '0;
                    state_next = S_SEEK;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next.bit_value_out = res_bit_reg;
                    out_next.run_start     = res_start_reg;
                    out_next.status        = res_status_reg;
                    out_valid_next         = 1'b1;
                    waddr_next             = '0;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            waddr_reg     <= '0;
            out_valid_reg <= 1'b0;
            bit_count_reg <= BIT_COUNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            waddr_reg     <= waddr_next;
            out_valid_reg <= out_valid_next;
            bit_count_reg <= bit_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        pass_reg       <= pass_next;
        base_reg       <= base_next;
        cb_reg         <= cb_next;
        c_reg          <= c_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        run_reg        <= run_next;
        val_reg        <= val_next;
        hit_pos_reg    <= hit_pos_next;
        word_reg       <= word_next;
        res_bit_reg    <= res_bit_next;
        res_start_reg  <= res_start_next;
        res_status_reg <= res_status_next;
        out_reg        <= out_next;
    end

endmodule

`default_nettype wire

### rtl/brsa_checker.sv
// Port-level assertion checker for the bitmap run scan allocator, with bind.
`default_nettype none

`include "assert_macros.svh"

module brsa_checker import brsa_pkg::*; (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_stall,
    input wire logic             out_valid,
    input wire logic             out_stall,
    input wire brsa_out_t        out_data
);

    // result beat carries a bit or a run start
    logic fields_set;

    assign fields_set = out_data.bit_value_out || (out_data.run_start != '0);

    // held result beat keeps its payload
    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

    // one operation at a time
    `CHK_NEXT(a_busy_after_beat, clk, rst_n, in_valid && !in_stall, in_stall)

    // clearing pass runs right after reset
    `CHK_IMPLY(a_clear_after_reset, clk, rst_n, !$past(rst_n), in_stall)

    // only a successful op reports a bit or a run start
    `CHK_IMPLY(a_fields_need_ok, clk, rst_n, out_valid && fields_set, out_data.status == STAT_OK)

endmodule

bind bitmap_run_scan_allocator brsa_checker u_brsa_checker (.*);

`default_nettype wire

### test/tb_bitmap_run_scan_allocator.sv
// Testbench for the bitmap run scan allocator: directed table, random ops, scoreboard.
`timescale 1ns / 100ps

module tb_bitmap_run_scan_allocator import brsa_pkg::*;;

    localparam int MAX_BITS    = 1024;
    localparam int WORD_BITS   = 8;
    localparam int WORD_COUNT  = MAX_BITS / WORD_BITS;
    localparam int CLK_PERIOD  = 10;
    // Worst op is a scan and flip, which walks the map a second time for the flip.
    // Budget the worst op for every beat plus long gaps and stalls, then several times over.
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int TAIL_CYCLES = 8 * WORD_COUNT;
    localparam int NUM_PHASES  = 10;
    localparam int HEAVY_PCT   = 78;
    localparam int MIXED_PCT   = 24;

    // Opcodes the block does not define; they must come back as bad argument.
    localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

    typedef struct {
        brsa_in_t  cmd;
        bit        known;   // result typed into the table
        brsa_out_t want;
    } op_row_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_data  = '0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    brsa_in_t         in_data   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    brsa_out_t        out_data;

    // Travels with each input beat so the monitor knows whether the table
    // already holds the answer.
    bit               beat_known = 1'b0;
    brsa_out_t        beat_want  = '0;

    // Shadow copy of the block: bitmap contents and the bit count register.
    bit [MAX_BITS-1:0] model_bits  = '0;
    logic [IDX_W-1:0]  model_count = BIT_COUNT_RESET;

    brsa_out_t    pending_results[$];
    brsa_out_t    predicted;
    brsa_out_t    oldest;
    op_row_t      directed_rows[$];
    int unsigned  mismatch_count = 0;
    int unsigned  result_count   = 0;
    int unsigned  cycle_count    = 0;
    int unsigned  send_idle_pct  = 0;
    int unsigned  stall_pct      = 0;

    // Per-phase bit count (phase 0 keeps the reset value, phase 8 picks a
    // random small count) and beat count.
    int unsigned phase_bits [NUM_PHASES] = '{1024, 0, 1, 2047, 200, 64, 1024, 1023, 0, 8};
    int unsigned phase_beats[NUM_PHASES] = '{150, 30, 60, 150, 150, 150, 150, 150, 150, 80};

    always #(CLK_PERIOD / 2) clk = ~clk;

    bitmap_run_scan_allocator #(
        .MAX_BITS (MAX_BITS),
        .WORD_BITS(WORD_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    // Computes the result of one op on the shadow bitmap and applies its
    // side effects (fill, range write, flip of the found run).
    function automatic brsa_out_t bitmap_op_result(brsa_in_t cmd);
        brsa_out_t   res;
        int unsigned usable, first, last, len, run, at, k;
        bit          hit;
        res    = '0;
        hit    = 1'b0;
        run    = 0;
        at     = 0;
        usable = (model_count > MAX_BITS) ? MAX_BITS : model_count;
        first  = cmd.start_index;
        last   = cmd.end_index;
        len    = cmd.run_length;
        res.status = STAT_OK;
        case (cmd.op)
            OP_FILL:
                // Fill covers the whole store, also bits past the bit count.
                model_bits = {MAX_BITS{cmd.bit_value_in}};
            OP_WRITE:
                if (first >= usable || len > usable - first)
                    res.status = STAT_BAD;
                else
                    for (k = first; k < first + len; k++)
                        model_bits[k] = cmd.bit_value_in;
            OP_READ:
                if (first >= usable)
                    res.status = STAT_BAD;
                else
                    res.bit_value_out = model_bits[first];
            OP_SCAN, OP_SCAN_FLIP:
                if (len == 0 || first > last || last > usable) begin
                    res.status = STAT_BAD;
                end
                else begin
                    // A window shorter than the run can never hold it.
                    if (last - first >= len)
                        for (k = first; k < last && !hit; k++) begin
                            if (model_bits[k] == cmd.bit_value_in) begin
                                run++;
                                if (run == len) begin
                                    hit = 1'b1;
                                    at  = k + 1 - len;
                                end
                            end
                            else begin
                                run = 0;
                            end
                        end
                    if (!hit) begin
                        res.status = STAT_NONE;
                    end
                    else begin
                        res.run_start = RUN_START_W'(at);
                        if (cmd.op == OP_SCAN_FLIP)
                            for (k = at; k < at + len; k++)
                                model_bits[k] = !cmd.bit_value_in;
                    end
                end
            default:
                res.status = STAT_BAD;
        endcase
        return res;
    endfunction

    task automatic flag_mismatch(input string field, input logic [15:0] seen,
                                 input logic [15:0] want);
        $display("mismatch on result %0d, %s: got %0d, expected %0d",
                 result_count, field, seen, want);
        mismatch_count++;
    endtask

    task automatic add_row(input logic [OP_W-1:0] op, input int s, input int e, input int len,
                           input bit v, input bit known, input bit bv, input int rs,
                           input logic [STATUS_W-1:0] st);
        op_row_t row;
        row.cmd.op                 = op;
        row.cmd.start_index        = IDX_W'(s);
        row.cmd.end_index          = IDX_W'(e);
        row.cmd.run_length         = IDX_W'(len);
        row.cmd.bit_value_in       = v;
        row.known                  = known;
        row.want.bit_value_out     = bv;
        row.want.run_start         = RUN_START_W'(rs);
        row.want.status            = st;
        directed_rows.push_back(row);
    endtask

    // Mostly well-formed ops sized to the current bit count; about one in
    // ten is noise with every field random over its full width.
    function automatic brsa_in_t random_op(int unsigned usable);
        brsa_in_t    cmd;
        int unsigned pick, room, span;
        cmd              = '0;
        cmd.bit_value_in = 1'($urandom_range(1));
        pick             = $urandom_range(99);
        if (pick < 10 || usable == 0) begin
            cmd.op          = OP_W'($urandom_range(7));
            cmd.start_index = IDX_W'($urandom);
            cmd.end_index   = IDX_W'($urandom);
            cmd.run_length  = IDX_W'($urandom);
            return cmd;
        end
        cmd.start_index = IDX_W'($urandom_range(usable - 1));
        room            = usable - cmd.start_index;
        if (pick < 14) begin
            cmd.op = OP_FILL;
        end
        else if (pick < 40) begin
            cmd.op         = OP_WRITE;
            span           = ($urandom_range(3) == 0 || room < 16) ? room : 16;
            cmd.run_length = IDX_W'($urandom_range(span));
        end
        else if (pick < 58) begin
            cmd.op = OP_READ;
        end
        else begin
            // Short windows keep most scans cheap; a quarter span the rest
            // of the map. Run lengths now and then exceed the window.
            cmd.op        = (pick < 76) ? OP_SCAN : OP_SCAN_FLIP;
            span          = ($urandom_range(3) == 0 || room < 40) ? room : 40;
            cmd.end_index = IDX_W'(cmd.start_index + $urandom_range(span));
            if ($urandom_range(7) == 0)
                cmd.run_length = IDX_W'(1 + $urandom_range(span));
            else
                cmd.run_length = IDX_W'(1 + $urandom_range(5));
        end
        return cmd;
    endfunction

    // Presents one op beat after a random gap; returns on the accepting edge.
    // in_valid stays high into the next beat when there is no gap.
    task automatic send_op(input brsa_in_t cmd, input bit known, input brsa_out_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_data    <= cmd;
        beat_known <= known;
        beat_want  <= want;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic write_bit_count(input int unsigned bits);
        cfg_valid <= 1'b1;
        cfg_data  <= IDX_W'(bits);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Receiver side: stall at random per cycle, at the rate of the phase.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Watchdog.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    // Monitor: register writes and accepted ops update the shadow model,
    // accepted results are checked against the oldest expectation.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                model_count = cfg_data;
            if (in_valid && !in_stall) begin
                predicted = bitmap_op_result(in_data);
                pending_results.push_back(beat_known ? beat_want : predicted);
            end
            if (out_valid && !out_stall) begin
                result_count++;
                if (pending_results.size() == 0) begin
                    flag_mismatch("result with nothing pending", 16'(out_data), '0);
                end
                else begin
                    oldest = pending_results.pop_front();
                    if (out_data.bit_value_out !== oldest.bit_value_out)
                        flag_mismatch("bit_value_out", 16'(out_data.bit_value_out),
                                      16'(oldest.bit_value_out));
                    if (out_data.run_start !== oldest.run_start)
                        flag_mismatch("run_start", 16'(out_data.run_start),
                                      16'(oldest.run_start));
                    if (out_data.status !== oldest.status)
                        flag_mismatch("status", 16'(out_data.status), 16'(oldest.status));
                end
            end
        end
    end

    initial begin
        int unsigned bits, usable;
        // Directed table, run at the reset bit count on a cleared map.
        // Rows with known = 0 go to the predictor.
        add_row(OP_READ,         0,    0,    0, 0, 1, 0,    0, STAT_OK);
        add_row(OP_READ,      1023,    0,    0, 0, 1, 0,    0, STAT_OK);
        add_row(OP_READ,      1024,    0,    0, 0, 1, 0,    0, STAT_BAD);
        add_row(OP_READ,      2047, 2047, 2047, 1, 1, 0,    0, STAT_BAD);
        add_row(OP_SCAN,         0, 1024, 1024, 0, 1, 0,    0, STAT_OK);
        add_row(OP_SCAN_FLIP,    0, 1024,    0, 0, 1, 0,    0, STAT_BAD);  // zero length
        add_row(OP_SCAN,         5,    4,    1, 0, 1, 0,    0, STAT_BAD);  // start past end
        add_row(OP_SCAN,         0, 1025,    1, 0, 1, 0,    0, STAT_BAD);  // end past count
        add_row(OP_SCAN,        10,   12,    3, 0, 1, 0,    0, STAT_NONE); // short window
        add_row(OP_SCAN,         0, 1024,    1, 1, 1, 0,    0, STAT_NONE); // no run of ones
        add_row(OP_WRITE,     1024,    0,    0, 1, 1, 0,    0, STAT_BAD);
        add_row(OP_WRITE,     1000,    0,   25, 1, 1, 0,    0, STAT_BAD);  // overruns count
        add_row(OP_WRITE,     1023,    0,    1, 1, 1, 0,    0, STAT_OK);
        add_row(OP_WRITE,        0,    0,    0, 1, 1, 0,    0, STAT_OK);   // empty range
        add_row(OP_WRITE,        3,    0,   10, 1, 1, 0,    0, STAT_OK);
        add_row(OP_READ,      1023,    0,    0, 0, 0, 0,    0, STAT_OK);
        add_row(OP_SCAN_FLIP,    0, 1024,    5, 0, 0, 0,    0, STAT_OK);
        add_row(OP_SCAN,         0, 1024, 2047, 0, 1, 0,    0, STAT_NONE);
        add_row(OP_UNDEF_LO,     0,    0,    0, 0, 1, 0,    0, STAT_BAD);
        add_row(OP_UNDEF_HI,  2047, 2047, 2047, 1, 1, 0,    0, STAT_BAD);
        add_row(OP_FILL,         0,    0,    0, 1, 1, 0,    0, STAT_OK);
        add_row(OP_SCAN,         0, 1024, 1024, 1, 1, 0,    0, STAT_OK);
        add_row(OP_SCAN_FLIP, 1020, 1024,    4, 1, 1, 0, 1020, STAT_OK);
        add_row(OP_READ,      1021,    0,    0, 0, 0, 0,    0, STAT_OK);
        add_row(OP_FILL,         0,    0,    0, 0, 1, 0,    0, STAT_OK);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The block clears its map after reset; the first beat just waits
        // for in_stall to drop.
        foreach (directed_rows[r])
            send_op(directed_rows[r].cmd, directed_rows[r].known, directed_rows[r].want);

        for (int p = 0; p < NUM_PHASES; p++) begin
            bits = phase_bits[p];
            if (p > 0) begin
                // Register writes only with the block idle: every result back
                // and the sequencer waiting for a beat.
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_results.size() != 0 || in_stall);
                repeat (4) @(posedge clk);
                if (p == 8)
                    bits = $urandom_range(100, 2);
                write_bit_count(bits);
            end
            usable = (bits > MAX_BITS) ? MAX_BITS : bits;
            // Rotate: no gaps, heavy sender gaps, heavy receiver stalls, both.
            case (p % 4)
                0: begin send_idle_pct = 0;         stall_pct = 0;         end
                1: begin send_idle_pct = HEAVY_PCT; stall_pct = 0;         end
                2: begin send_idle_pct = 0;         stall_pct = HEAVY_PCT; end
                default: begin send_idle_pct = MIXED_PCT; stall_pct = MIXED_PCT; end
            endcase
            repeat (phase_beats[p])
                send_op(random_op(usable), 1'b0, '0);
        end
        in_valid <= 1'b0;

        do
            @(posedge clk);
        while (pending_results.size() != 0 || in_stall);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
